/* design/tlkc_pkg.sv */
package tlkc_pkg;

  localparam int CNT_W  = 7;
  localparam int KIND_W = 2;
  localparam int CHILD_W = 7;
  localparam int REC_W  = KIND_W + 2 * CHILD_W;

  localparam logic [KIND_W-1:0] KIND_GREEN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RED   = 2'd2;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE = 4'd0;
  localparam step_t STEP_INIT = 4'd1;
  localparam step_t STEP_ROOT = 4'd2;
  localparam step_t STEP_LVL  = 4'd3;
  localparam step_t STEP_DEQ  = 4'd4;
  localparam step_t STEP_QRD  = 4'd5;
  localparam step_t STEP_NRD  = 4'd6;
  localparam step_t STEP_LK   = 4'd7;
  localparam step_t STEP_RK   = 4'd8;
  localparam step_t STEP_FIN  = 4'd9;

  // Jump conditions, tested after the hold condition.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_LAST,
    COND_Q_EMPTY,
    COND_LVL_DONE
  } cond_e;

  // Conditions that keep the step counter where it is.
  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_ACCEPT,
    HOLD_COMMIT,
    HOLD_FIN
  } hold_e;

  typedef struct packed {
    logic  in_rdy;
    logic  init;
    logic  tally;
    logic  commit;
    logic  deq;
    logic  node_rd;
    logic  visit_left;
    logic  visit_right;
    logic  finish;
    hold_e hold;
    cond_e cond;
    step_t jump;
  } cw_t;

  function automatic cw_t cw_rom(input step_t step);
    cw_t cw;
    cw = '{in_rdy: 1'b0, init: 1'b0, tally: 1'b0, commit: 1'b0, deq: 1'b0,
           node_rd: 1'b0, visit_left: 1'b0, visit_right: 1'b0, finish: 1'b0,
           hold: HOLD_NONE, cond: COND_ALWAYS, jump: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        cw.in_rdy = 1'b1;
        cw.hold   = HOLD_ACCEPT;
        cw.cond   = COND_NOT_LAST;
        cw.jump   = STEP_IDLE;
      end
      STEP_INIT: begin
        cw.init = 1'b1;
        cw.cond = COND_NEVER;
      end
      STEP_ROOT: begin
        cw.tally = 1'b1;
        cw.cond  = COND_NEVER;
      end
      STEP_LVL: begin
        cw.commit = 1'b1;
        cw.hold   = HOLD_COMMIT;
        cw.cond   = COND_Q_EMPTY;
        cw.jump   = STEP_FIN;
      end
      STEP_DEQ: begin
        cw.deq  = 1'b1;
        cw.cond = COND_LVL_DONE;
        cw.jump = STEP_LVL;
      end
      STEP_QRD: begin
        cw.node_rd = 1'b1;
        cw.cond    = COND_NEVER;
      end
      STEP_NRD: begin
        cw.visit_left = 1'b1;
        cw.cond       = COND_NEVER;
      end
      STEP_LK: begin
        cw.tally       = 1'b1;
        cw.visit_right = 1'b1;
        cw.cond        = COND_NEVER;
      end
      STEP_RK: begin
        cw.tally = 1'b1;
        cw.jump  = STEP_DEQ;
      end
      STEP_FIN: begin
        cw.finish = 1'b1;
        cw.hold   = HOLD_FIN;
        cw.jump   = STEP_IDLE;
      end
      default: begin
        cw.jump = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

/* design/tlkc_ram.sv */
module tlkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* design/tree_level_kind_counter.sv */
// Loading takes one node record per cycle; the walk starts after the last record.
// Walk: setup, then a commit step per depth level and a node step per dequeued node, then a
// finish; commit and finish may wait on the output. Each node step is a chain of
// registered reads: queue entry, node record, then the kind of each child.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and clears the node count;
// node and queue tables hold no value until written.
module tree_level_kind_counter #(
  parameter int MAX_NODES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tlkc_pkg::KIND_W-1:0]  node_kind_i,
  input  logic [tlkc_pkg::CHILD_W-1:0] left_child_i,
  input  logic [tlkc_pkg::CHILD_W-1:0] right_child_i,
  input  logic                        last_node_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tlkc_pkg::CNT_W-1:0]   green_count_o,
  output logic [tlkc_pkg::CNT_W-1:0]   red_count_o,
  output logic                        last_level_o
);

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [tlkc_pkg::CNT_W-1:0] MaxCnt = tlkc_pkg::CNT_W'(MAX_NODES);

  tlkc_pkg::step_t step_q, step_d;
  tlkc_pkg::cw_t   cw;

  logic [tlkc_pkg::CNT_W-1:0] loaded_q, head_q, tail_q, level_end_q;
  logic [tlkc_pkg::CNT_W-1:0] acc_g_q, acc_r_q, pend_g_q, pend_r_q;
  logic [tlkc_pkg::CNT_W-1:0] out_g_q, out_r_q;
  logic                       pend_valid_q, out_valid_q, out_last_q, vis_q;
  logic [tlkc_pkg::CHILD_W-1:0] right_q;

  logic in_acc, out_free, acc_nz, hold, cond;
  logic [tlkc_pkg::CHILD_W-1:0] child;
  logic [tlkc_pkg::CHILD_W-1:0] child_m1;
  logic child_ok, visit;

  logic                       node_we;
  logic [IW-1:0]              node_raddr;
  logic [tlkc_pkg::REC_W-1:0] node_rdata;
  logic [tlkc_pkg::KIND_W-1:0] rd_kind;
  logic [tlkc_pkg::CHILD_W-1:0] rd_left;

  logic          q_we;
  logic [IW-1:0] q_waddr, q_wdata, q_rdata;

  assign cw       = tlkc_pkg::cw_rom(step_q);
  assign in_ready_o = cw.in_rdy;
  assign in_acc   = in_valid_i && cw.in_rdy;
  assign out_free = !out_valid_q || out_ready_i;
  assign acc_nz   = (acc_g_q != '0) || (acc_r_q != '0);

  assign rd_kind = node_rdata[tlkc_pkg::REC_W-1 -: tlkc_pkg::KIND_W];
  assign rd_left = node_rdata[2*tlkc_pkg::CHILD_W-1 -: tlkc_pkg::CHILD_W];

  // Sequencer: hold first, then a conditional jump, else the next step.
  always_comb begin
    unique case (cw.hold)
      tlkc_pkg::HOLD_NONE:   hold = 1'b0;
      tlkc_pkg::HOLD_ACCEPT: hold = !in_acc;
      tlkc_pkg::HOLD_COMMIT: hold = acc_nz && pend_valid_q && !out_free;
      tlkc_pkg::HOLD_FIN:    hold = pend_valid_q && !out_free;
      default:               hold = 1'b0;
    endcase
    unique case (cw.cond)
      tlkc_pkg::COND_NEVER:    cond = 1'b0;
      tlkc_pkg::COND_ALWAYS:   cond = 1'b1;
      tlkc_pkg::COND_NOT_LAST: cond = !last_node_i;
      tlkc_pkg::COND_Q_EMPTY:  cond = (head_q == tail_q);
      tlkc_pkg::COND_LVL_DONE: cond = (head_q == level_end_q);
      default:                 cond = 1'b0;
    endcase
    priority if (hold) begin
      step_d = step_q;
    end else if (cond) begin
      step_d = cw.jump;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  // Child under test: the left one straight from the record, the right one latched.
  assign child    = cw.visit_left ? rd_left : right_q;
  assign child_m1 = child - 1'b1;
  assign child_ok = (child != '0) && (child <= loaded_q) && (tail_q < MaxCnt);
  assign visit    = (cw.visit_left || cw.visit_right) && child_ok;

  always_comb begin
    if (cw.init) begin
      node_raddr = '0;
    end else if (cw.node_rd) begin
      node_raddr = q_rdata;
    end else begin
      node_raddr = child_m1[IW-1:0];
    end
  end

  assign node_we = in_acc && (loaded_q < MaxCnt);
  assign q_we    = cw.init || visit;
  assign q_waddr = cw.init ? '0 : tail_q[IW-1:0];
  assign q_wdata = cw.init ? '0 : child_m1[IW-1:0];

  tlkc_ram #(
    .WIDTH(tlkc_pkg::REC_W),
    .DEPTH(MAX_NODES)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (node_we),
    .waddr_i(loaded_q[IW-1:0]),
    .wdata_i({node_kind_i, left_child_i, right_child_i}),
    .raddr_i(node_raddr),
    .rdata_o(node_rdata)
  );

  tlkc_ram #(
    .WIDTH(IW),
    .DEPTH(MAX_NODES)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(q_waddr),
    .wdata_i(q_wdata),
    .raddr_i(head_q[IW-1:0]),
    .rdata_o(q_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= tlkc_pkg::STEP_IDLE;
      loaded_q     <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      level_end_q  <= '0;
      acc_g_q      <= '0;
      acc_r_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      vis_q        <= 1'b0;
    end else begin
      step_q <= step_d;
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (node_we) begin
        loaded_q <= loaded_q + 1'b1;
      end
      if (cw.init) begin
        head_q       <= '0;
        tail_q       <= tlkc_pkg::CNT_W'(1);
        acc_g_q      <= '0;
        acc_r_q      <= '0;
        pend_valid_q <= 1'b0;
        vis_q        <= 1'b1;
      end
      if (cw.tally && vis_q) begin
        if (rd_kind == tlkc_pkg::KIND_GREEN) begin
          acc_g_q <= acc_g_q + 1'b1;
        end else if (rd_kind == tlkc_pkg::KIND_RED) begin
          acc_r_q <= acc_r_q + 1'b1;
        end
      end
      if (cw.visit_left || cw.visit_right) begin
        vis_q <= child_ok;
        if (child_ok) begin
          tail_q <= tail_q + 1'b1;
        end
      end
      if (cw.visit_left) begin
        right_q <= node_rdata[tlkc_pkg::CHILD_W-1:0];
      end
      if (cw.deq && (head_q != level_end_q)) begin
        head_q <= head_q + 1'b1;
      end
      // Level boundary: the counts of the level about to be walked are complete.
      // A nonzero level is held until the next nonzero level or the finish, so the final one can be flagged.
      if (cw.commit && !hold) begin
        level_end_q <= tail_q;
        acc_g_q     <= '0;
        acc_r_q     <= '0;
        if (acc_nz) begin
          pend_g_q     <= acc_g_q;
          pend_r_q     <= acc_r_q;
          pend_valid_q <= 1'b1;
          if (pend_valid_q) begin
            out_valid_q <= 1'b1;
            out_g_q     <= pend_g_q;
            out_r_q     <= pend_r_q;
            out_last_q  <= 1'b0;
          end
        end
      end
      if (cw.finish && !hold) begin
        loaded_q     <= '0;
        pend_valid_q <= 1'b0;
        if (pend_valid_q) begin
          out_valid_q <= 1'b1;
          out_g_q     <= pend_g_q;
          out_r_q     <= pend_r_q;
          out_last_q  <= 1'b1;
        end
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign green_count_o = out_g_q;
  assign red_count_o   = out_r_q;
  assign last_level_o  = out_last_q;

endmodule

/* design/tlkc_checker.sv */
module tlkc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       last_node_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [6:0] green_count_o,
  input logic [6:0] red_count_o,
  input logic       last_level_o
);

  // The last record of a tree starts the walk, so no word is taken next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_node_i) |=> !in_ready_o)
    else $error("input still ready after the last node record");

  // Any other record keeps the block loading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !last_node_i) |=> in_ready_o)
    else $error("input not ready after a plain node record");

  // Results are produced only by a walk, never while records are loading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while loading");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(green_count_o) && $stable(red_count_o)
       && $stable(last_level_o)))
    else $error("stalled result word changed");

endmodule

bind tree_level_kind_counter tlkc_checker u_tlkc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .last_node_i  (last_node_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .green_count_o(green_count_o),
  .red_count_o  (red_count_o),
  .last_level_o (last_level_o)
);

/* verif/tree_level_kind_counter_test.sv */
`timescale 1ns / 100ps

module tree_level_kind_counter_test;

  localparam int NODE_LIMIT  = 64;
  localparam int MAX_RECORDS = NODE_LIMIT + 2;
  // Bound on the longest walk: setup, each level, each dequeued node, finish.
  localparam int WALK_CYCLES = 2 + 2 * NODE_LIMIT + 5 * NODE_LIMIT + 2;

  typedef enum int {
    SHAPE_BRANCHY,
    SHAPE_CHAIN,
    SHAPE_NOISE
  } tree_shape_e;

  typedef struct {
    logic [tlkc_pkg::CNT_W-1:0] green;
    logic [tlkc_pkg::CNT_W-1:0] red;
    logic                       last;
  } level_counts_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_ready_o;
  logic [tlkc_pkg::KIND_W-1:0]  node_kind_i   = '0;
  logic [tlkc_pkg::CHILD_W-1:0] left_child_i  = '0;
  logic [tlkc_pkg::CHILD_W-1:0] right_child_i = '0;
  logic                         last_node_i   = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i   = 1'b0;
  logic [tlkc_pkg::CNT_W-1:0]   green_count_o;
  logic [tlkc_pkg::CNT_W-1:0]   red_count_o;
  logic                         last_level_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;

  // Predictor state: the loaded tree and the per-level tallies of one walk.
  logic [tlkc_pkg::KIND_W-1:0]  kind_tbl  [NODE_LIMIT];
  logic [tlkc_pkg::CHILD_W-1:0] left_tbl  [NODE_LIMIT];
  logic [tlkc_pkg::CHILD_W-1:0] right_tbl [NODE_LIMIT];
  int unsigned                  nodes_held = 0;
  logic [tlkc_pkg::CNT_W-1:0]   green_at  [NODE_LIMIT];
  logic [tlkc_pkg::CNT_W-1:0]   red_at    [NODE_LIMIT];

  level_counts_t expected_levels[$];
  level_counts_t want_level;

  tree_level_kind_counter #(
    .MAX_NODES(NODE_LIMIT)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .node_kind_i  (node_kind_i),
    .left_child_i (left_child_i),
    .right_child_i(right_child_i),
    .last_node_i  (last_node_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .green_count_o(green_count_o),
    .red_count_o  (red_count_o),
    .last_level_o (last_level_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void tally_kind(input int unsigned lvl,
                                     input logic [tlkc_pkg::KIND_W-1:0] kind);
    if (lvl < NODE_LIMIT) begin
      if (kind == tlkc_pkg::KIND_GREEN) begin
        green_at[lvl] = green_at[lvl] + 1'b1;
      end else if (kind == tlkc_pkg::KIND_RED) begin
        red_at[lvl] = red_at[lvl] + 1'b1;
      end
    end
  endfunction

  // Store one node record; on the last one, walk the tree and queue the level counts.
  function automatic void absorb_node_record(input logic [tlkc_pkg::KIND_W-1:0] kind,
                                             input logic [tlkc_pkg::CHILD_W-1:0] left,
                                             input logic [tlkc_pkg::CHILD_W-1:0] right,
                                             input logic last);
    int unsigned walk_q [NODE_LIMIT];
    int unsigned head;
    int unsigned tail;
    int unsigned depth;
    int unsigned level_end;
    int unsigned node;
    int unsigned child;
    int          final_level;
    int          i;
    int          c;
    level_counts_t lc;
    if (nodes_held < NODE_LIMIT) begin
      kind_tbl[nodes_held]  = kind;
      left_tbl[nodes_held]  = left;
      right_tbl[nodes_held] = right;
      nodes_held++;
    end
    if (!last) return;
    for (i = 0; i < NODE_LIMIT; i++) begin
      green_at[i] = '0;
      red_at[i]   = '0;
    end
    walk_q[0] = 0;
    tail      = 1;
    head      = 0;
    depth     = 0;
    tally_kind(0, kind_tbl[0]);
    while (head < tail) begin
      level_end = tail;
      while (head < level_end) begin
        node = walk_q[head];
        head++;
        for (c = 0; c < 2; c++) begin
          child = (c == 0) ? left_tbl[node] : right_tbl[node];
          // Children beyond the loaded nodes count as absent; the queue caps the walk.
          if (child != 0 && child <= nodes_held && tail < NODE_LIMIT) begin
            walk_q[tail] = child - 1;
            tail++;
            tally_kind(depth + 1, kind_tbl[child - 1]);
          end
        end
      end
      depth++;
    end
    final_level = -1;
    for (i = 0; i < depth && i < NODE_LIMIT; i++) begin
      if (green_at[i] != 0 || red_at[i] != 0) final_level = i;
    end
    for (i = 0; i <= final_level; i++) begin
      if (green_at[i] != 0 || red_at[i] != 0) begin
        lc.green = green_at[i];
        lc.red   = red_at[i];
        lc.last  = (i == final_level);
        expected_levels.push_back(lc);
      end
    end
    nodes_held = 0;
  endfunction

  // Inputs are folded into the prediction before outputs are checked in the same edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      absorb_node_record(node_kind_i, left_child_i, right_child_i, last_node_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected level word green %0d red %0d last %0b",
                                  green_count_o, red_count_o, last_level_o));
      end else begin
        want_level = expected_levels.pop_front();
        if (green_count_o !== want_level.green) begin
          report_mismatch($sformatf("green_count got %0d expected %0d",
                                    green_count_o, want_level.green));
        end
        if (red_count_o !== want_level.red) begin
          report_mismatch($sformatf("red_count got %0d expected %0d",
                                    red_count_o, want_level.red));
        end
        if (last_level_o !== want_level.last) begin
          report_mismatch($sformatf("last_level got %0b expected %0b",
                                    last_level_o, want_level.last));
        end
      end
    end
  end

  // Entered and left at a falling edge; valid stays high for a following word.
  task automatic send_node_record(input logic [tlkc_pkg::KIND_W-1:0] kind,
                                  input logic [tlkc_pkg::CHILD_W-1:0] left,
                                  input logic [tlkc_pkg::CHILD_W-1:0] right,
                                  input logic last);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    node_kind_i   <= kind;
    left_child_i  <= left;
    right_child_i <= right;
    last_node_i   <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_levels_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_levels.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_tree(input int unsigned n, input tree_shape_e shape);
    logic [tlkc_pkg::CHILD_W-1:0] lkid  [MAX_RECORDS];
    logic [tlkc_pkg::CHILD_W-1:0] rkid  [MAX_RECORDS];
    logic [tlkc_pkg::KIND_W-1:0]  kinds [MAX_RECORDS];
    int unsigned                  i;
    int unsigned                  p;
    bit                           placed;
    for (i = 0; i < n; i++) begin
      lkid[i]  = '0;
      rkid[i]  = '0;
      kinds[i] = tlkc_pkg::KIND_W'($urandom_range(0, 3));
    end
    for (i = 0; i < n; i++) begin
      if (i >= NODE_LIMIT) begin
        // Records past the table size are dropped, so their content is arbitrary.
        lkid[i] = tlkc_pkg::CHILD_W'($urandom_range(0, 127));
        rkid[i] = tlkc_pkg::CHILD_W'($urandom_range(0, 127));
      end else if (shape == SHAPE_CHAIN) begin
        kinds[i] = tlkc_pkg::KIND_W'($urandom_range(1, 2));
        if (i + 1 < n && i + 1 < NODE_LIMIT) lkid[i] = tlkc_pkg::CHILD_W'(i + 2);
      end else if (shape == SHAPE_NOISE) begin
        case ($urandom_range(0, 3))
          0:       lkid[i] = '0;
          3:       lkid[i] = tlkc_pkg::CHILD_W'($urandom_range(0, 127));
          default: lkid[i] = tlkc_pkg::CHILD_W'($urandom_range(1, n));
        endcase
        case ($urandom_range(0, 3))
          0:       rkid[i] = '0;
          3:       rkid[i] = tlkc_pkg::CHILD_W'($urandom_range(0, 127));
          default: rkid[i] = tlkc_pkg::CHILD_W'($urandom_range(1, n));
        endcase
      end else if (i > 0) begin
        placed = 1'b0;
        while (!placed) begin
          p = $urandom_range(0, i - 1);
          if (lkid[p] == 0 && ($urandom_range(1) == 1 || rkid[p] != 0)) begin
            lkid[p] = tlkc_pkg::CHILD_W'(i + 1);
            placed  = 1'b1;
          end else if (rkid[p] == 0) begin
            rkid[p] = tlkc_pkg::CHILD_W'(i + 1);
            placed  = 1'b1;
          end
        end
      end
    end
    for (i = 0; i < n; i++) begin
      send_node_record(kinds[i], lkid[i], rkid[i], i == n - 1);
    end
  endtask

  task automatic test_single_root();
    send_node_record(tlkc_pkg::KIND_GREEN, 7'd0, 7'd0, 1'b1);
    send_node_record(tlkc_pkg::KIND_RED, 7'd0, 7'd0, 1'b1);
    // Neither kind at the root leaves every level empty: no word comes back.
    send_node_record(2'd0, 7'd0, 7'd0, 1'b1);
    send_node_record(2'd3, 7'd0, 7'd0, 1'b1);
    wait_levels_drained();
  endtask

  task automatic test_child_range();
    send_node_record(tlkc_pkg::KIND_GREEN, 7'd2, 7'd3, 1'b0);
    send_node_record(tlkc_pkg::KIND_RED, 7'd127, 7'd65, 1'b0);
    send_node_record(tlkc_pkg::KIND_GREEN, 7'd64, 7'd4, 1'b1);
    send_node_record(tlkc_pkg::KIND_RED, 7'd5, 7'd2, 1'b0);
    send_node_record(2'd3, 7'd0, 7'd0, 1'b1);
    wait_levels_drained();
  endtask

  task automatic test_cyclic_tree();
    send_node_record(tlkc_pkg::KIND_GREEN, 7'd1, 7'd1, 1'b1);
    send_node_record(2'd0, 7'd2, 7'd0, 1'b0);
    send_node_record(tlkc_pkg::KIND_RED, 7'd1, 7'd2, 1'b1);
    wait_levels_drained();
  endtask

  task automatic test_empty_levels();
    send_node_record(2'd0, 7'd2, 7'd0, 1'b0);
    send_node_record(2'd3, 7'd0, 7'd3, 1'b0);
    send_node_record(tlkc_pkg::KIND_GREEN, 7'd0, 7'd0, 1'b1);
    send_node_record(tlkc_pkg::KIND_RED, 7'd2, 7'd3, 1'b0);
    send_node_record(2'd0, 7'd0, 7'd0, 1'b0);
    send_node_record(2'd3, 7'd0, 7'd0, 1'b1);
    wait_levels_drained();
  endtask

  task automatic test_full_tables();
    recv_stall_pct = 62;
    send_tree(NODE_LIMIT, SHAPE_CHAIN);
    send_tree(NODE_LIMIT + 2, SHAPE_CHAIN);
    wait_levels_drained();
    recv_stall_pct = 0;
  endtask

  task automatic test_random_trees();
    int unsigned send_pcts [4];
    int unsigned recv_pcts [4];
    int unsigned ph;
    int unsigned sent;
    int unsigned n;
    send_pcts = '{0, 62, 0, 21};
    recv_pcts = '{0, 0, 62, 21};
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      sent = 0;
      while (sent < 12) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_tree(n, ($urandom_range(9) < 7) ? SHAPE_BRANCHY : SHAPE_NOISE);
        sent += n;
      end
    end
    wait_levels_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_single_root();
    test_child_range();
    test_cyclic_tree();
    test_empty_levels();
    test_full_tables();
    test_random_trees();
    repeat (WALK_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
design/tlkc_pkg.sv
design/tlkc_ram.sv
design/tree_level_kind_counter.sv
design/tlkc_checker.sv
verif/tree_level_kind_counter_test.sv
